// ===== design/spq_pkg.sv =====
// Shared types, sizes and codes for the sorted priority queue.
`default_nettype none

package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VAL_W   = 32;
    localparam int PRIO_W  = 8;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;
    localparam int ENTRY_W = VAL_W + PRIO_W;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS0,
        S_FIND,
        S_SHIFT,
        S_RESP
    } t_state;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [PRIO_W-1:0]       prio;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic                    valid;
        t_status                 status;
        logic signed [VAL_W-1:0] value;
        logic [CNT_W-1:0]        count;
    } t_result;

endpackage

`default_nettype wire

// ===== design/spq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module spq_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 40
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/spq_ctrl.sv =====
// Sequencer that walks the sorted store one entry a cycle for insert and remove.
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic                    i_cmd,
    input  wire logic signed [VAL_W-1:0] i_value,
    input  wire logic [PRIO_W-1:0]       i_prio,
    input  wire logic                    i_out_free,
    input  wire t_entry                  i_rdata,
    output logic                         o_busy,
    output t_ram_req                     o_req,
    output t_result                      o_res
);

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [ADDR_W-1:0]       r_idx, n_idx;
    logic signed [VAL_W-1:0] r_value, n_value;
    logic [PRIO_W-1:0]       r_prio, n_prio;
    t_status                 r_status, n_status;
    logic signed [VAL_W-1:0] r_removed, n_removed;

    logic [CNT_W-1:0]  count_m1;
    logic [ADDR_W-1:0] idx_p1;
    logic [CNT_W-1:0]  idx_ext;
    logic [CNT_W-1:0]  idx_p1_ext;
    logic              is_full;
    logic              is_empty;
    logic              prio_gt;
    logic              prio_eq;
    logic              prio_lt;

    assign count_m1   = r_count - CNT_W'(1);
    assign idx_p1     = r_idx + ADDR_W'(1);
    assign idx_ext    = {{(CNT_W-ADDR_W){1'b0}}, r_idx};
    assign idx_p1_ext = idx_ext + CNT_W'(1);
    assign is_full    = (r_count == CNT_W'(DEPTH));
    assign is_empty   = (r_count == '0);

    // the priority comparison against the read entry, used by the insert and find steps
    assign prio_gt = (i_rdata.prio > r_prio);
    assign prio_eq = (i_rdata.prio == r_prio);
    assign prio_lt = !prio_gt && !prio_eq;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_cmd == CMD_INSERT) begin
                        n_state = (is_full || is_empty) ? S_RESP : S_INS;
                    end else begin
                        n_state = is_empty ? S_RESP : S_FIND;
                    end
                end
            end
            S_INS: begin
                if (prio_gt) begin
                    n_state = (r_idx == '0) ? S_INS0 : S_INS;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_INS0: n_state = S_RESP;
            S_FIND: begin
                if (prio_eq) begin
                    n_state = (idx_ext == count_m1) ? S_RESP : S_SHIFT;
                end else if (prio_lt || r_idx == '0) begin
                    n_state = S_RESP;
                end
            end
            S_SHIFT: begin
                if (idx_p1_ext == count_m1) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_value   = r_value;
        n_prio    = r_prio;
        n_status  = r_status;
        n_removed = r_removed;
        o_req     = '0;
        o_req.raddr = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_value     = i_value;
                    n_prio      = i_prio;
                    n_removed   = '0;
                    n_status    = ST_DONE;
                    n_idx       = count_m1[ADDR_W-1:0];
                    o_req.raddr = count_m1[ADDR_W-1:0];
                    if (i_cmd == CMD_INSERT) begin
                        if (is_full) begin
                            n_status = ST_FULL;
                        end else if (is_empty) begin
                            o_req.we          = 1'b1;
                            o_req.waddr       = '0;
                            o_req.wdata.value = i_value;
                            o_req.wdata.prio  = i_prio;
                            n_count           = r_count + CNT_W'(1);
                        end
                    end else if (is_empty) begin
                        n_status = ST_NOT_FOUND;
                    end
                end
            end
            S_INS: begin
                o_req.we    = 1'b1;
                o_req.waddr = idx_p1;
                if (prio_gt) begin
                    // move the higher entry up one slot and keep walking down
                    o_req.wdata = i_rdata;
                    o_req.raddr = r_idx - ADDR_W'(1);
                    n_idx       = r_idx - ADDR_W'(1);
                end else begin
                    o_req.wdata.value = r_value;
                    o_req.wdata.prio  = r_prio;
                    n_count           = r_count + CNT_W'(1);
                end
            end
            S_INS0: begin
                o_req.we          = 1'b1;
                o_req.waddr       = '0;
                o_req.wdata.value = r_value;
                o_req.wdata.prio  = r_prio;
                n_count           = r_count + CNT_W'(1);
            end
            S_FIND: begin
                if (prio_eq) begin
                    n_removed = i_rdata.value;
                    if (idx_ext == count_m1) begin
                        n_count = count_m1;
                    end else begin
                        o_req.raddr = idx_p1;
                    end
                end else if (prio_lt || r_idx == '0) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    o_req.raddr = r_idx - ADDR_W'(1);
                    n_idx       = r_idx - ADDR_W'(1);
                end
            end
            S_SHIFT: begin
                // close the gap: entry above moves down into this slot
                o_req.we    = 1'b1;
                o_req.waddr = r_idx;
                o_req.wdata = i_rdata;
                if (idx_p1_ext == count_m1) begin
                    n_count = count_m1;
                end else begin
                    o_req.raddr = r_idx + ADDR_W'(2);
                    n_idx       = idx_p1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_value   <= n_value;
        r_prio    <= n_prio;
        r_status  <= n_status;
        r_removed <= n_removed;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_res.valid  = (r_state == S_RESP);
    assign o_res.status = r_status;
    assign o_res.value  = r_removed;
    assign o_res.count  = r_count;

endmodule

`default_nettype wire

// ===== design/sorted_priority_queue.sv =====
// Sorted priority queue: up to DEPTH entries kept in ascending priority order.
// Insert into an empty or full store goes straight to the result; else it walks down
// from the top, moving each held entry above the insert point up one slot.
// Remove walks down to the match then shifts the upper part; one command at a time,
// the next accepted once the result is in the output register.
// Reset (synchronous, active low) empties the store; entry contents are not cleared.
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic                    i_cmd,
    input  wire logic signed [VAL_W-1:0] i_item_value,
    input  wire logic [PRIO_W-1:0]       i_item_priority,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [STAT_W-1:0]            o_status,
    output logic signed [VAL_W-1:0]      o_removed_value,
    output logic [COUNT_W-1:0]           o_entry_count
);

    logic                    busy;
    logic                    start;
    logic                    out_free;
    t_ram_req                req;
    t_result                 res;
    t_entry                  rdata;
    logic [ENTRY_W-1:0]      rdata_bits;
    logic [CNT_W+COUNT_W-1:0] count_wide;

    logic                    r_out_valid;
    logic [STAT_W-1:0]       r_status;
    logic signed [VAL_W-1:0] r_removed_value;
    logic [COUNT_W-1:0]      r_entry_count;

    assign start    = i_in_valid && !busy;
    assign out_free = !r_out_valid || !i_out_stall;
    assign rdata    = t_entry'(rdata_bits);
    assign count_wide = {{COUNT_W{1'b0}}, res.count};

    spq_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (req.we),
        .i_waddr (req.waddr),
        .i_wdata (req.wdata),
        .i_raddr (req.raddr),
        .o_rdata (rdata_bits)
    );

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cmd      (i_cmd),
        .i_value    (i_item_value),
        .i_prio     (i_item_priority),
        .i_out_free (out_free),
        .i_rdata    (rdata),
        .o_busy     (busy),
        .o_req      (req),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && out_free) begin
            r_status        <= res.status;
            r_removed_value <= res.value;
            r_entry_count   <= count_wide[COUNT_W-1:0];
        end
    end

    assign o_in_stall      = busy;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed_value;
    assign o_entry_count   = r_entry_count;

endmodule

`default_nettype wire

// ===== design/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
`default_nettype none

module spq_checker
    import spq_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    o_in_stall,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_stall,
    input wire logic [STAT_W-1:0]       o_status,
    input wire logic signed [VAL_W-1:0] o_removed_value,
    input wire logic [COUNT_W-1:0]      o_entry_count
);

    localparam logic [CNT_W+COUNT_W-1:0] DEPTH_WIDE = (CNT_W + COUNT_W)'(DEPTH);
    localparam logic [COUNT_W-1:0]       DEPTH_OUT  = DEPTH_WIDE[COUNT_W-1:0];

    // an accepted command always leaves the idle state, so the input stalls after a beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted beat");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_entry_count == DEPTH_OUT))
        else $error("full reported with store not full");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_DONE) |-> (o_removed_value == '0))
        else $error("removed value not zero on a failed command");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_DONE || o_status == ST_FULL
                         || o_status == ST_NOT_FOUND))
        else $error("undefined status code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_entry_count)))
        else $error("stalled result beat changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_removed_value (o_removed_value),
    .o_entry_count   (o_entry_count)
);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the sorted priority queue: directed and random commands.
`timescale 1ns / 1ps

module tb;
    import spq_pkg::*;

    typedef struct {
        t_status                 status;
        logic signed [VAL_W-1:0] value;
        logic [COUNT_W-1:0]      count;
    } t_cmd_outcome;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_cmd = CMD_INSERT;
    logic signed [VAL_W-1:0] i_item_value = '0;
    logic [PRIO_W-1:0]       i_item_priority = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [STAT_W-1:0]       o_status;
    logic signed [VAL_W-1:0] o_removed_value;
    logic [COUNT_W-1:0]      o_entry_count;

    // shadow copy of the sorted store
    logic signed [VAL_W-1:0] slot_val [DEPTH];
    logic [PRIO_W-1:0]       slot_prio [DEPTH];
    int                      held = 0;

    t_cmd_outcome pending_outcomes [$];
    int           mismatches = 0;
    bit           no_gaps = 1'b0;
    int unsigned  out_hold_req = 0;

    sorted_priority_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_entry_count   (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #(5_000_000);
        $display("Mismatches found");
        $finish;
    end

    // Applies one command to the shadow store and returns the outcome it must produce.
    function automatic t_cmd_outcome apply_command(input logic cmd,
                                                   input logic signed [VAL_W-1:0] value,
                                                   input logic [PRIO_W-1:0] prio);
        t_cmd_outcome res;
        int pos;
        int hit;
        int i;
        res.status = ST_DONE;
        res.value  = '0;
        if (cmd == CMD_INSERT) begin
            if (held >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < held && slot_prio[pos] <= prio) pos++;
                for (i = held; i > pos; i--) begin
                    slot_val[i]  = slot_val[i-1];
                    slot_prio[i] = slot_prio[i-1];
                end
                slot_val[pos]  = value;
                slot_prio[pos] = prio;
                held++;
            end
        end else begin
            // latest arrival of a priority sits last among its equals
            hit = -1;
            for (i = 0; i < held; i++)
                if (slot_prio[i] == prio) hit = i;
            if (hit < 0) begin
                res.status = ST_NOT_FOUND;
            end else begin
                res.value = slot_val[hit];
                for (i = hit; i + 1 < held; i++) begin
                    slot_val[i]  = slot_val[i+1];
                    slot_prio[i] = slot_prio[i+1];
                end
                held--;
            end
        end
        res.count = COUNT_W'(held);
        return res;
    endfunction

    task automatic send_cmd(input logic cmd, input logic signed [VAL_W-1:0] value,
                            input logic [PRIO_W-1:0] prio);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= cmd;
        i_item_value    <= value;
        i_item_priority <= prio;
        do @(posedge i_clk); while (o_in_stall);
        pending_outcomes.push_back(apply_command(cmd, value, prio));
    endtask

    task automatic wait_idle();
        int n;
        n = 0;
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0 && n < 5000) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    // output side: random stall before each beat, or a long hold on request
    initial begin : receiver
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 15);
            if (out_hold_req != 0) begin
                gap = out_hold_req;
                out_hold_req = 0;
            end
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        t_cmd_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outcomes.size() == 0) begin
                $error("result beat with no command pending: status %0d value %0d count %0d",
                       o_status, o_removed_value, o_entry_count);
                mismatches++;
            end else begin
                want = pending_outcomes.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_removed_value !== want.value) begin
                    $error("removed_value: expected %0d, got %0d", want.value, o_removed_value);
                    mismatches++;
                end
                if (o_entry_count !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, o_entry_count);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_empty_remove();
        send_cmd(CMD_REMOVE, $urandom, 8'd0);
        send_cmd(CMD_REMOVE, $urandom, 8'd255);
        wait_idle();
    endtask

    // extremes of value and priority, equal priorities, miss on a non-empty store
    task automatic test_extremes();
        send_cmd(CMD_INSERT, 32'sh7FFF_FFFF, 8'd255);
        send_cmd(CMD_INSERT, 32'sh8000_0000, 8'd0);
        send_cmd(CMD_INSERT, -32'sd1, 8'd128);
        send_cmd(CMD_INSERT, 32'sd0, 8'd0);
        send_cmd(CMD_INSERT, 32'sh5555_AAAA, 8'd0);
        send_cmd(CMD_REMOVE, $urandom, 8'd0);
        send_cmd(CMD_REMOVE, $urandom, 8'd77);
        send_cmd(CMD_REMOVE, $urandom, 8'd255);
        wait_idle();
    endtask

    task automatic test_fill_to_full();
        while (held < DEPTH)
            send_cmd(CMD_INSERT, $urandom, PRIO_W'($urandom_range(0, 255)));
        send_cmd(CMD_INSERT, $urandom, 8'd0);
        wait_idle();
    endtask

    task automatic test_random(input int n_items, input int insert_pct, input int prio_hi);
        int k;
        logic cmd;
        logic [PRIO_W-1:0] prio;
        for (k = 0; k < n_items; k++) begin
            if (held == 0)
                cmd = ($urandom_range(0, 9) == 0) ? CMD_REMOVE : CMD_INSERT;
            else if (held >= DEPTH)
                cmd = ($urandom_range(0, 3) == 0) ? CMD_INSERT : CMD_REMOVE;
            else
                cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
            // removes mostly aim at a held priority
            if (cmd == CMD_REMOVE && held > 0 && $urandom_range(0, 9) != 0)
                prio = slot_prio[$urandom_range(0, held - 1)];
            else
                prio = PRIO_W'($urandom_range(0, prio_hi));
            send_cmd(cmd, $urandom, prio);
        end
        wait_idle();
    endtask

    task automatic test_output_hold();
        out_hold_req = 300;
        test_random(25, 50, 15);
    endtask

    task automatic test_sender_pause();
        test_random(10, 60, 255);
        test_random(10, 40, 255);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_remove();
        test_extremes();
        test_fill_to_full();

        test_random(200, 70, 255);
        test_random(200, 30, 3);
        test_output_hold();
        test_random(150, 60, 3);
        no_gaps = 1'b1;
        test_random(100, 50, 15);
        no_gaps = 1'b0;
        test_sender_pause();
        test_random(150, 50, 255);

        repeat (50) @(posedge i_clk);
        if (pending_outcomes.size() != 0) begin
            $error("results never arrived: %0d outstanding", pending_outcomes.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
